[hw/rtl/iir_pkg.sv]
// Shared widths, command codes and control structs of the transposed direct form II IIR filter.
`default_nettype none

package iir_pkg;

  localparam int DEF_MAX_ORDER = 4;

  localparam int CMD_W    = 2;
  localparam int IDX_W    = 4;
  localparam int TAPCNT_W = 4;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 32;
  localparam int ACC_W    = 48;
  localparam int PROD_W   = COEF_W + SAMPLE_W;
  localparam int FRAC_W   = 24;
  localparam int SUM_W    = ACC_W + 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_WR_FF  = 2'd1,
    CMD_WR_FB  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic ld_x;
    logic y_pass;
    logic y_en;
    logic mul_en;
    logic mul_a;
    logic acc_en;
    logic z_zero;
  } mac_ctl_t;

  typedef struct packed {
    logic we_b;
    logic we_a;
    logic re;
  } cst_ctl_t;

  typedef struct packed {
    logic clr_all;
    logic clr_one;
    logic we;
    logic re;
  } dly_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/iir_stream_if.sv]
// Valid/ready channel interfaces for filter commands and filtered samples.
`default_nettype none

interface iir_in_if;
  logic                                    valid;
  logic                                    ready;
  logic        [iir_pkg::CMD_W-1:0]        command;
  logic        [iir_pkg::IDX_W-1:0]        tap_index;
  logic signed [iir_pkg::COEF_W-1:0]       coefficient;
  logic signed [iir_pkg::SAMPLE_W-1:0]     sample_in;

  modport source(output valid, output command, output tap_index, output coefficient,
                 output sample_in, input ready);
  modport sink(input valid, input command, input tap_index, input coefficient,
               input sample_in, output ready);
endinterface

interface iir_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [iir_pkg::SAMPLE_W-1:0] sample_out;
  logic                                saturated;

  modport source(output valid, output sample_out, output saturated, input ready);
  modport sink(input valid, input sample_out, input saturated, output ready);
endinterface

`default_nettype wire

[hw/rtl/iir_coef_store.sv]
// Coefficient memory holding feedforward and feedback lanes per tap, with per-lane valid bits.
`default_nettype none

module iir_coef_store #(
  parameter int DEPTH = 2 * iir_pkg::DEF_MAX_ORDER + 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  iir_pkg::cst_ctl_t                 ctl,
  input  logic [$clog2(DEPTH)-1:0]          waddr,
  input  logic signed [iir_pkg::COEF_W-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0]          raddr,
  output logic signed [iir_pkg::COEF_W-1:0] coef_b,
  output logic signed [iir_pkg::COEF_W-1:0] coef_a
);

  logic [1:0][iir_pkg::COEF_W-1:0] coef_mem_r [DEPTH];
  logic [1:0][iir_pkg::COEF_W-1:0] rdata_r;
  logic [DEPTH-1:0]                b_vld_r;
  logic [DEPTH-1:0]                a_vld_r;
  logic [1:0]                      rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.we_b) begin
      coef_mem_r[waddr][0] <= wdata;
    end
    if (ctl.we_a) begin
      coef_mem_r[waddr][1] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= coef_mem_r[raddr];
    end
  end

  // A lane that was never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r  <= '0;
      a_vld_r  <= '0;
      rd_vld_r <= '0;
    end else begin
      if (ctl.we_b) begin
        b_vld_r[waddr] <= 1'b1;
      end
      if (ctl.we_a) begin
        a_vld_r[waddr] <= 1'b1;
      end
      if (ctl.re) begin
        rd_vld_r <= {a_vld_r[raddr], b_vld_r[raddr]};
      end
    end
  end

  assign coef_b = rd_vld_r[0] ? rdata_r[0] : '0;
  assign coef_a = rd_vld_r[1] ? rdata_r[1] : '0;

endmodule

`default_nettype wire

[hw/rtl/iir_delay_store.sv]
// Delay-line memory with per-entry valid bits, so that clearing resets valid bits, not memory words.
`default_nettype none

module iir_delay_store #(
  parameter int DEPTH = 2 * iir_pkg::DEF_MAX_ORDER
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  iir_pkg::dly_ctl_t                ctl,
  input  logic [$clog2(DEPTH)-1:0]         clr_idx,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic signed [iir_pkg::ACC_W-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic signed [iir_pkg::ACC_W-1:0] z
);

  logic [iir_pkg::ACC_W-1:0] dly_mem_r [DEPTH];
  logic [iir_pkg::ACC_W-1:0] rdata_r;
  logic [DEPTH-1:0]          vld_r;
  logic                      rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      dly_mem_r[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= dly_mem_r[raddr];
    end
  end

  // An entry that is not valid reads as zero, so clearing only touches valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.clr_one) begin
        vld_r[clr_idx] <= 1'b0;
      end
      if (ctl.we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (ctl.clr_all) begin
        vld_r <= '0;
      end
      if (ctl.re) begin
        rd_vld_r <= vld_r[raddr];
      end
    end
  end

  assign z = rd_vld_r ? rdata_r : '0;

endmodule

`default_nettype wire

[hw/rtl/iir_mac.sv]
// Shared multiply-accumulate datapath with output rounding and clipping and delay saturation.
`default_nettype none

module iir_mac (
  input  logic                                clk,
  input  iir_pkg::mac_ctl_t                   ctl,
  input  logic signed [iir_pkg::SAMPLE_W-1:0] x_in,
  input  logic signed [iir_pkg::COEF_W-1:0]   coef_b,
  input  logic signed [iir_pkg::COEF_W-1:0]   coef_a,
  input  logic signed [iir_pkg::ACC_W-1:0]    z_in,
  output logic signed [iir_pkg::SAMPLE_W-1:0] y,
  output logic                                sat,
  output logic signed [iir_pkg::ACC_W-1:0]    wb_data
);

  localparam int SW = iir_pkg::SAMPLE_W;
  localparam int AW = iir_pkg::ACC_W;
  localparam int UW = iir_pkg::SUM_W;
  localparam int QW = UW - iir_pkg::FRAC_W;
  localparam logic signed [UW-1:0] ROUND_C = UW'(1) << (iir_pkg::FRAC_W - 1);
  localparam logic signed [SW-1:0] Y_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] Y_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [AW-1:0] Z_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] Z_MIN = {1'b1, {(AW-1){1'b0}}};

  logic signed [SW-1:0]               x_r;
  logic signed [SW-1:0]               y_r;
  logic                               sat_r;
  logic signed [iir_pkg::PROD_W-1:0]  prod_r;
  logic signed [AW:0]                 acc_r;

  logic signed [iir_pkg::COEF_W-1:0]  mul_coef;
  logic signed [SW-1:0]               mul_opnd;
  logic signed [iir_pkg::PROD_W-1:0]  prod_nxt;
  logic signed [AW-1:0]               z_eff;
  logic signed [AW:0]                 acc_nxt;
  logic signed [UW-1:0]               ysum;
  logic        [QW-1:0]               yq;
  logic        [QW-SW:0]              yq_top;
  logic                               y_fits;
  logic signed [SW-1:0]               y_nxt;
  logic signed [UW-1:0]               diff;
  logic        [UW-AW:0]              diff_top;

  assign mul_coef = ctl.mul_a ? coef_a : coef_b;
  assign mul_opnd = ctl.mul_a ? y_r : x_r;
  assign prod_nxt = mul_coef * mul_opnd;
  assign z_eff    = ctl.z_zero ? '0 : z_in;
  assign acc_nxt  = (AW + 1)'(prod_r) + (AW + 1)'(z_eff);

  // Round half up to an integer, then clip to the sample range.
  assign ysum   = UW'(prod_r) + UW'(z_eff) + ROUND_C;
  assign yq     = ysum[UW-1:iir_pkg::FRAC_W];
  assign yq_top = yq[QW-1:SW-1];
  assign y_fits = (&yq_top) || !(|yq_top);
  assign y_nxt  = y_fits ? yq[SW-1:0] : (yq[QW-1] ? Y_MIN : Y_MAX);

  assign diff     = UW'(acc_r) - UW'(prod_r);
  assign diff_top = diff[UW-1:AW-1];
  assign wb_data  = ((&diff_top) || !(|diff_top)) ? diff[AW-1:0]
                                                  : (diff[UW-1] ? Z_MIN : Z_MAX);

  always_ff @(posedge clk) begin
    if (ctl.ld_x) begin
      x_r <= x_in;
    end
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctl.acc_en) begin
      acc_r <= acc_nxt;
    end
    if (ctl.y_pass) begin
      y_r   <= x_in;
      sat_r <= 1'b0;
    end else if (ctl.y_en) begin
      y_r   <= y_nxt;
      sat_r <= !y_fits;
    end
  end

  assign y   = y_r;
  assign sat = sat_r;

endmodule

`default_nettype wire

[hw/rtl/iir_filter_transposed_df2.sv]
// Top level of the fixed-point transposed direct form II IIR filter with its tap sequencer.
//
// Coefficient writes and delay clears complete in the cycle they are accepted. A sample
// transaction with n active taps (tap_count limited to 2*MAX_ORDER+1) occupies the block
// until the sequencer is back in idle and takes no new command meanwhile: P and Q for tap
// zero, PUT, and with more taps P and Q for each of them and WB; pass-through is PUT only.
// One shared 32x16 multiplier forms two products per tap after tap zero (feedforward times
// the input, feedback times the output) and only the first for tap zero; each tap's
// memories are read ahead of its P state. The result is formed in tap zero's Q state and
// registered in PUT, and the remaining delay updates continue behind it; if the previous
// result has not yet been taken, the sequencer holds until the output register is free.
`default_nettype none

module iir_filter_transposed_df2 #(
  parameter int MAX_ORDER = iir_pkg::DEF_MAX_ORDER
) (
  input  logic                            clk,
  input  logic                            rst_n,
  iir_in_if.sink                          in_ch,
  iir_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [iir_pkg::TAPCNT_W-1:0]    cfg_wdata
);

  localparam int NUM_TAPS   = 2 * MAX_ORDER + 1;
  localparam int NUM_DELAYS = 2 * MAX_ORDER;
  localparam int NW         = $clog2(NUM_TAPS + 1);
  localparam int CW         = $clog2(NUM_TAPS);
  localparam int DW         = $clog2(NUM_DELAYS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_P,
    S_Q,
    S_PUT,
    S_WB
  } state_t;

  state_t                            state_r, state_nxt;
  logic [iir_pkg::TAPCNT_W-1:0]      tap_count_r;
  logic [NW-1:0]                     n_r, n_nxt;
  logic [NW-1:0]                     tap_r, tap_nxt;
  logic                              pend_r, pend_nxt;
  logic [DW-1:0]                     wb_addr_r, wb_addr_nxt;
  logic                              out_valid_r;
  logic signed [iir_pkg::SAMPLE_W-1:0] out_sample_r;
  logic                              out_sat_r;

  logic                              accept;
  iir_pkg::cmd_t                     in_cmd;
  logic                              tap_in_range;
  logic [NW-1:0]                     n_cfg;
  logic [NW-1:0]                     n_cfg_m1;
  logic [NW-1:0]                     tap_inc;
  logic [NW-1:0]                     tap_dec;
  logic                              last_tap;
  logic                              out_free;
  logic                              load_out;
  logic [NW-1:0]                     rd_addr;

  iir_pkg::mac_ctl_t                 mac_ctl;
  iir_pkg::cst_ctl_t                 cst_ctl;
  iir_pkg::dly_ctl_t                 dly_ctl;
  logic signed [iir_pkg::COEF_W-1:0]   coef_b;
  logic signed [iir_pkg::COEF_W-1:0]   coef_a;
  logic signed [iir_pkg::ACC_W-1:0]    z;
  logic signed [iir_pkg::SAMPLE_W-1:0] y;
  logic                                sat;
  logic signed [iir_pkg::ACC_W-1:0]    wb_data;
  logic [DW-1:0]                       dly_raddr;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_cmd       = iir_pkg::cmd_t'(in_ch.command);
  assign tap_in_range = 32'(in_ch.tap_index) < NUM_TAPS;
  assign n_cfg        = (32'(tap_count_r) > NUM_TAPS) ? NW'(NUM_TAPS) : NW'(tap_count_r);
  assign n_cfg_m1     = n_cfg - NW'(1);
  assign tap_inc      = tap_r + NW'(1);
  assign tap_dec      = tap_r - NW'(1);
  assign last_tap     = (tap_r == n_r - NW'(1));
  assign out_free     = !out_valid_r || out_ch.ready;
  assign dly_raddr    = rd_addr[DW-1:0];

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.saturated  = out_sat_r;

  // Tap i uses states P and Q: P forms b[i]*x and retires the previous tap's delay update,
  // Q forms a[i]*y, accumulates b[i]*x + z[i] and fetches tap i+1. Tap zero produces y.
  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    tap_nxt     = tap_r;
    pend_nxt    = pend_r;
    wb_addr_nxt = wb_addr_r;
    load_out    = 1'b0;
    rd_addr     = '0;
    mac_ctl     = '0;
    cst_ctl     = '0;
    dly_ctl     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            iir_pkg::CMD_WR_FF: begin
              cst_ctl.we_b = tap_in_range;
            end
            iir_pkg::CMD_WR_FB: begin
              cst_ctl.we_a = tap_in_range;
            end
            iir_pkg::CMD_CLEAR: begin
              dly_ctl.clr_all = 1'b1;
            end
            iir_pkg::CMD_SAMPLE: begin
              mac_ctl.ld_x = 1'b1;
              n_nxt        = n_cfg;
              tap_nxt      = '0;
              pend_nxt     = 1'b0;
              if (n_cfg == '0) begin
                mac_ctl.y_pass = 1'b1;
                state_nxt      = S_PUT;
              end else begin
                cst_ctl.re      = 1'b1;
                dly_ctl.re      = 1'b1;
                dly_ctl.clr_one = (n_cfg <= NW'(NUM_DELAYS));
                state_nxt       = S_P;
              end
            end
          endcase
        end
      end
      S_P: begin
        mac_ctl.mul_en = 1'b1;
        dly_ctl.we     = pend_r;
        pend_nxt       = 1'b0;
        state_nxt      = S_Q;
      end
      S_Q: begin
        mac_ctl.z_zero = last_tap;
        tap_nxt        = tap_inc;
        if (tap_r == '0) begin
          mac_ctl.y_en = 1'b1;
        end else begin
          mac_ctl.acc_en = 1'b1;
          mac_ctl.mul_en = 1'b1;
          mac_ctl.mul_a  = 1'b1;
          pend_nxt       = 1'b1;
          wb_addr_nxt    = tap_dec[DW-1:0];
        end
        if (tap_inc < n_r) begin
          cst_ctl.re = 1'b1;
          dly_ctl.re = (tap_inc < NW'(NUM_DELAYS));
          rd_addr    = tap_inc;
        end
        if (tap_r == '0) begin
          state_nxt = S_PUT;
        end else if (tap_inc < n_r) begin
          state_nxt = S_P;
        end else begin
          state_nxt = S_WB;
        end
      end
      S_PUT: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = (tap_r < n_r) ? S_P : S_IDLE;
        end
      end
      S_WB: begin
        dly_ctl.we = 1'b1;
        pend_nxt   = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap_count_r <= '0;
      n_r         <= '0;
      tap_r       <= '0;
      pend_r      <= 1'b0;
      wb_addr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      n_r       <= n_nxt;
      tap_r     <= tap_nxt;
      pend_r    <= pend_nxt;
      wb_addr_r <= wb_addr_nxt;
      if (cfg_we) begin
        tap_count_r <= cfg_wdata;
      end
      if (load_out) begin
        out_valid_r  <= 1'b1;
        out_sample_r <= y;
        out_sat_r    <= sat;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  iir_coef_store #(
    .DEPTH (NUM_TAPS)
  ) u_coef (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (cst_ctl),
    .waddr  (CW'(in_ch.tap_index)),
    .wdata  (in_ch.coefficient),
    .raddr  (rd_addr[CW-1:0]),
    .coef_b (coef_b),
    .coef_a (coef_a)
  );

  iir_delay_store #(
    .DEPTH (NUM_DELAYS)
  ) u_delay (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (dly_ctl),
    .clr_idx (n_cfg_m1[DW-1:0]),
    .waddr   (wb_addr_r),
    .wdata   (wb_data),
    .raddr   (dly_raddr),
    .z       (z)
  );

  iir_mac u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .x_in    (in_ch.sample_in),
    .coef_b  (coef_b),
    .coef_a  (coef_a),
    .z_in    (z),
    .y       (y),
    .sat     (sat),
    .wb_data (wb_data)
  );

  a_no_raw_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && dly_ctl.re) |-> (dly_raddr != wb_addr_r))
    else $error("delay read hits an entry whose update is still pending");

  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (tap_r <= n_r))
    else $error("tap counter ran past the active tap count");

  a_put_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT && out_free) |=> out_valid_r)
    else $error("result slot not filled after leaving the output state");

  a_wb_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |-> pend_r)
    else $error("final delay write-back without a pending update");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == iir_pkg::CMD_SAMPLE) |=> (state_r != S_IDLE))
    else $error("sample transaction did not start the sequencer");

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the transposed direct form II IIR filter with stream channels.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     NUM_COEFS     = 2 * iir_pkg::DEF_MAX_ORDER + 1;
  localparam int     NUM_STAGES    = 2 * iir_pkg::DEF_MAX_ORDER;
  localparam int     IW            = iir_pkg::IDX_W;
  localparam int     SW            = iir_pkg::SAMPLE_W;
  localparam int     TW            = iir_pkg::TAPCNT_W;
  localparam int     SETTLE_CYCLES = 40;
  localparam int     RX_HOLD       = 200;
  localparam int     CYCLE_LIMIT   = 250000;
  localparam longint ACC_HI        = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO        = -ACC_HI - 1;
  localparam longint ROUND_HALF    = 64'sd8388608;

  typedef struct packed {
    logic signed [iir_pkg::SAMPLE_W-1:0] sample;
    logic                                sat;
  } filt_out_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [iir_pkg::TAPCNT_W-1:0] cfg_wdata;

  iir_in_if  in_bus();
  iir_out_if out_bus();

  iir_filter_transposed_df2 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic signed [iir_pkg::COEF_W-1:0] ff_coef [NUM_COEFS];
  logic signed [iir_pkg::COEF_W-1:0] fb_coef [NUM_COEFS];
  logic signed [iir_pkg::ACC_W-1:0]  z_state [NUM_STAGES];
  logic [iir_pkg::TAPCNT_W-1:0]      taps_cfg;
  filt_out_t                         pending_outputs[$];

  int  fail_count      = 0;
  int  cycle_count     = 0;
  int  rx_wait         = 0;
  int  holds_requested = 0;
  int  holds_served    = 0;
  bit  tx_gaps_on;
  bit  rx_gaps_on;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (holds_served != holds_requested) begin
      holds_served = holds_requested;
      rx_wait = RX_HOLD;
      out_bus.ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_bus.ready <= 1'b0;
    end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
      rx_wait = $urandom_range(0, 2);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    filt_out_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_outputs.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected output transaction: sample %0d sat %0b",
                   out_bus.sample_out, out_bus.saturated);
        fail_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_bus.sample_out !== want.sample || out_bus.saturated !== want.sat) begin
          if (fail_count < 10)
            $display("output mismatch: expected sample %0d sat %0b, got sample %0d sat %0b",
                     want.sample, want.sat, out_bus.sample_out, out_bus.saturated);
          fail_count++;
        end
      end
    end
  end

  function automatic void filter_predict(iir_pkg::cmd_t c, logic [iir_pkg::IDX_W-1:0] idx,
                                         logic signed [iir_pkg::COEF_W-1:0] cf,
                                         logic signed [iir_pkg::SAMPLE_W-1:0] x);
    int        n;
    longint    acc;
    longint    y;
    longint    v;
    longint    zi;
    filt_out_t r;
    case (c)
      iir_pkg::CMD_WR_FF: if (idx < NUM_COEFS) ff_coef[idx] = cf;
      iir_pkg::CMD_WR_FB: if (idx < NUM_COEFS) fb_coef[idx] = cf;
      iir_pkg::CMD_CLEAR: foreach (z_state[i]) z_state[i] = '0;
      default: begin
        n = (taps_cfg > NUM_COEFS) ? NUM_COEFS : int'(taps_cfg);
        r.sat = 1'b0;
        if (n == 0) begin
          y = longint'(x);
        end else begin
          if (n - 1 < NUM_STAGES) z_state[n - 1] = '0;
          acc = longint'(ff_coef[0]) * longint'(x);
          if (n > 1) acc += longint'(z_state[0]);
          y = (acc + ROUND_HALF) >>> iir_pkg::FRAC_W;
          if (y > 32767) begin
            y = 32767;
            r.sat = 1'b1;
          end else if (y < -32768) begin
            y = -32768;
            r.sat = 1'b1;
          end
          for (int i = 1; i < n; i++) begin
            zi = 0;
            if (i < n - 1) zi = longint'(z_state[i]);
            v = longint'(ff_coef[i]) * longint'(x) + zi - longint'(fb_coef[i]) * y;
            if (v > ACC_HI) v = ACC_HI;
            else if (v < ACC_LO) v = ACC_LO;
            z_state[i - 1] = v[iir_pkg::ACC_W-1:0];
          end
        end
        r.sample = y[iir_pkg::SAMPLE_W-1:0];
        pending_outputs.push_back(r);
      end
    endcase
  endfunction

  function automatic logic signed [iir_pkg::COEF_W-1:0] rand_coef(int mag);
    return int'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  function automatic logic signed [iir_pkg::SAMPLE_W-1:0] rand_sample();
    if ($urandom_range(0, 1) == 0) return SW'($urandom());
    return SW'(int'($urandom_range(0, 4000)) - 2000);
  endfunction

  task automatic send_txn(iir_pkg::cmd_t c, logic [iir_pkg::IDX_W-1:0] idx,
                          logic signed [iir_pkg::COEF_W-1:0] cf,
                          logic signed [iir_pkg::SAMPLE_W-1:0] x);
    int gap;
    if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.command     <= c;
    in_bus.tap_index   <= idx;
    in_bus.coefficient <= cf;
    in_bus.sample_in   <= x;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    filter_predict(c, idx, cf, x);
    @(negedge clk);
  endtask

  task automatic send_sample(logic signed [iir_pkg::SAMPLE_W-1:0] x);
    send_txn(iir_pkg::CMD_SAMPLE, IW'($urandom()), $urandom(), x);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending_outputs.size() != 0) @(negedge clk);
  endtask

  task automatic quiesce();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_taps(logic [iir_pkg::TAPCNT_W-1:0] taps);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_wdata <= taps;
    @(negedge clk);
    cfg_we    <= 1'b0;
    taps_cfg = taps;
  endtask

  task automatic load_coefs(int ff_mag, int fb_mag);
    for (int i = 0; i < NUM_COEFS; i++) begin
      send_txn(iir_pkg::CMD_WR_FF, IW'(i), rand_coef(ff_mag), SW'($urandom()));
      send_txn(iir_pkg::CMD_WR_FB, IW'(i), rand_coef(fb_mag), SW'($urandom()));
    end
  endtask

  task automatic test_passthrough();
    send_sample(16'sh7FFF);
    send_sample(-16'sd32768);
    send_sample(16'sd0);
    send_sample(-16'sd1);
  endtask

  task automatic test_limits_and_saturation();
    send_txn(iir_pkg::CMD_WR_FB, 4'd0, 32'sh7FFF_FFFF, 16'sd0);
    send_txn(iir_pkg::CMD_WR_FF, 4'd15, 32'sh7FFF_FFFF, 16'sd0);
    send_txn(iir_pkg::CMD_WR_FB, 4'd9, -32'sd1, 16'sd0);
    send_txn(iir_pkg::CMD_WR_FF, 4'd8, 32'sh8000_0000, 16'sd0);
    send_txn(iir_pkg::CMD_WR_FB, 4'd8, 32'sh7FFF_FFFF, 16'sd0);
    send_txn(iir_pkg::CMD_WR_FF, 4'd0, 32'sh7FFF_FFFF, 16'sd0);
    write_taps(4'd15);
    send_sample(16'sh7FFF);
    send_sample(-16'sd32768);
    send_sample(16'sd1);
    send_txn(iir_pkg::CMD_CLEAR, IW'($urandom()), $urandom(), SW'($urandom()));
    send_sample(16'sd5);
    write_taps(4'd1);
    send_sample(-16'sd100);
    write_taps(4'd2);
    send_sample(16'sd3);
  endtask

  task automatic test_rounding();
    write_taps(4'd1);
    send_txn(iir_pkg::CMD_WR_FF, 4'd0, 32'sd8388608, 16'sd0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(-16'sd3);
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    int pick;
    logic [iir_pkg::TAPCNT_W-1:0] taps;
    for (int p = 0; p < phases; p++) begin
      case (p % 6)
        0: taps = 4'd9;
        1: taps = 4'd0;
        2: taps = 4'd15;
        3: taps = 4'd1;
        4: taps = 4'd2;
        default: taps = TW'($urandom_range(0, 15));
      endcase
      write_taps(taps);
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      if (p % 4 == 3) load_coefs(1 << 28, 1 << 28);
      else load_coefs(1 << 23, 1 << 21);
      for (int k = 0; k < per_phase; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 85)
          send_sample(rand_sample());
        else if (pick < 90)
          send_txn(iir_pkg::CMD_CLEAR, IW'($urandom()), $urandom(), SW'($urandom()));
        else if (pick < 95)
          send_txn(iir_pkg::cmd_t'(($urandom_range(0, 1) == 0) ? iir_pkg::CMD_WR_FF
                                                                 : iir_pkg::CMD_WR_FB),
                   IW'($urandom()), $urandom(), SW'($urandom()));
        else
          send_txn(iir_pkg::cmd_t'($urandom_range(0, 3)), IW'($urandom()), $urandom(),
                   SW'($urandom()));
      end
    end
  endtask

  task automatic test_output_backpressure();
    write_taps(4'd9);
    tx_gaps_on = 1'b0;
    load_coefs(1 << 23, 1 << 21);
    holds_requested++;
    for (int k = 0; k < 40; k++) send_sample(rand_sample());
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_sender_drain_pause();
    for (int k = 0; k < 15; k++) send_sample(rand_sample());
    wait_drained();
    for (int k = 0; k < 15; k++) send_sample(rand_sample());
  endtask

  task automatic test_gapless_tail();
    write_taps(4'd9);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    load_coefs(1 << 23, 1 << 21);
    for (int k = 0; k < 60; k++) send_sample(rand_sample());
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_bus.valid       = 1'b0;
    in_bus.command     = iir_pkg::CMD_SAMPLE;
    in_bus.tap_index   = '0;
    in_bus.coefficient = '0;
    in_bus.sample_in   = '0;
    taps_cfg           = '0;
    foreach (ff_coef[i]) ff_coef[i] = '0;
    foreach (fb_coef[i]) fb_coef[i] = '0;
    foreach (z_state[i]) z_state[i] = '0;
    tx_gaps_on      = 1'b1;
    rx_gaps_on      = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_passthrough();
    test_limits_and_saturation();
    test_rounding();
    test_random_phases(13, 70);
    test_output_backpressure();
    test_sender_drain_pause();
    test_gapless_tail();
    quiesce();

    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

[iir_filter_transposed_df2.f]
hw/rtl/iir_pkg.sv
hw/rtl/iir_stream_if.sv
hw/rtl/iir_coef_store.sv
hw/rtl/iir_delay_store.sv
hw/rtl/iir_mac.sv
hw/rtl/iir_filter_transposed_df2.sv
dv/tb_top.sv
